>>> hw/rtl/serial_boot_command_engine_assert.svh
// Assertion macros shared by the serial boot command engine RTL.
// Included by the top level; needs nothing else.
`ifndef SERIAL_BOOT_COMMAND_ENGINE_ASSERT_SVH
`define SERIAL_BOOT_COMMAND_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sbce_pkg.sv
// Shared types and constants of the serial boot command engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sbce_pkg;

  // Protocol byte codes.
  localparam logic [7:0] LOAD_REQ    = 8'hC0;
  localparam logic [7:0] LOAD_ACK    = 8'hC1;
  localparam logic [7:0] EXEC_REQ    = 8'hC2;
  localparam logic [7:0] EXEC_ACK    = 8'hC3;
  localparam logic [7:0] ECHO_REQ    = 8'hC4;
  localparam logic [7:0] ECHO_ACK    = 8'hC5;
  localparam logic [7:0] CLEAR_REQ   = 8'hC6;
  localparam logic [7:0] CLEAR_ACK   = 8'hC7;
  localparam logic [7:0] CMD_NAK     = 8'hC8;

  // FNV-1a-32 constants.
  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  // Result kinds.
  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_START = 2'd3;

  // Job operations passed from the front end to the back end.
  typedef logic [2:0] job_op_t;
  localparam job_op_t OP_REPLY      = 3'd0; // one transmit byte
  localparam job_op_t OP_EXEC       = 3'd1; // ack, then start program
  localparam job_op_t OP_WRITE      = 3'd2; // one memory byte write
  localparam job_op_t OP_WRITE_DONE = 3'd3; // final write, ack, four hash bytes
  localparam job_op_t OP_LOAD_DONE  = 3'd4; // ack and four hash bytes
  localparam job_op_t OP_CLEAR      = 3'd5; // clear request, then ack

  typedef struct packed {
    job_op_t     op;
    logic [7:0]  byte_value;
    logic [31:0] address;
    logic [31:0] arg;  // clear length, or the checksum for load completion
  } job_t;

  typedef struct packed {
    logic       halted;
    logic [1:0] phase;
  } front_status_t;

  typedef struct packed {
    logic       busy;
    logic [2:0] step;
  } back_status_t;

endpackage

>>> hw/rtl/sbce_front.sv
// Front end: accepts received bytes, tracks the command protocol and the
// checksum, and turns each byte into at most one job. Uses sbce_pkg.
`timescale 1ns / 1ps

module sbce_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  logic [7:0]             in_rx_byte,
  input  logic                   job_full,
  output logic                   job_push,
  output sbce_pkg::job_t         job,
  output sbce_pkg::front_status_t status
);
  import sbce_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ADDR = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic        clear_r, clear_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic        halted_r, halted_nxt;
  logic [31:0] hash_mul;
  logic [31:0] len_shift;
  logic        accept;

  assign accept    = in_push && !job_full;
  assign hash_mul  = (hash_r ^ {24'd0, in_rx_byte}) * HASH_PRIME;
  assign len_shift = {in_rx_byte, len_r[31:8]};

  always_comb begin
    phase_nxt  = phase_r;
    clear_nxt  = clear_r;
    idx_nxt    = idx_r;
    addr_nxt   = addr_r;
    len_nxt    = len_r;
    left_nxt   = left_r;
    hash_nxt   = hash_r;
    halted_nxt = halted_r;
    job_push   = 1'b0;
    job        = '{op: OP_REPLY, byte_value: 8'd0, address: 32'd0, arg: 32'd0};
    if (accept && !halted_r) begin
      unique case (phase_r)
        PH_IDLE: begin
          priority if (in_rx_byte == LOAD_REQ || in_rx_byte == CLEAR_REQ) begin
            clear_nxt = (in_rx_byte == CLEAR_REQ);
            idx_nxt   = 2'd0;
            phase_nxt = PH_ADDR;
          end else if (in_rx_byte == EXEC_REQ) begin
            job_push   = 1'b1;
            job.op     = OP_EXEC;
            halted_nxt = 1'b1;
          end else if (in_rx_byte == ECHO_REQ) begin
            job_push       = 1'b1;
            job.byte_value = ECHO_ACK;
          end else begin
            job_push       = 1'b1;
            job.byte_value = CMD_NAK;
          end
        end
        PH_ADDR: begin
          addr_nxt = {in_rx_byte, addr_r[31:8]};
          idx_nxt  = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          len_nxt = len_shift;
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            phase_nxt = PH_IDLE;
            if (clear_r) begin
              job_push    = 1'b1;
              job.op      = OP_CLEAR;
              job.address = addr_r;
              job.arg     = len_shift;
            end else begin
              hash_nxt = HASH_BASIS;
              left_nxt = len_shift;
              if (len_shift == 32'd0) begin
                job_push = 1'b1;
                job.op   = OP_LOAD_DONE;
                job.arg  = HASH_BASIS;
              end else begin
                phase_nxt = PH_DATA;
              end
            end
          end
        end
        PH_DATA: begin
          hash_nxt       = hash_mul;
          addr_nxt       = addr_r + 32'd1;
          left_nxt       = left_r - 32'd1;
          job_push       = 1'b1;
          job.byte_value = in_rx_byte;
          job.address    = addr_r;
          job.arg        = hash_mul;
          if (left_r == 32'd1) begin
            job.op    = OP_WRITE_DONE;
            phase_nxt = PH_IDLE;
          end else begin
            job.op = OP_WRITE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      clear_r  <= 1'b0;
      idx_r    <= 2'd0;
      addr_r   <= 32'd0;
      len_r    <= 32'd0;
      left_r   <= 32'd0;
      hash_r   <= HASH_BASIS;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      clear_r  <= clear_nxt;
      idx_r    <= idx_nxt;
      addr_r   <= addr_nxt;
      len_r    <= len_nxt;
      left_r   <= left_nxt;
      hash_r   <= hash_nxt;
      halted_r <= halted_nxt;
    end
  end

  assign status = '{halted: halted_r, phase: phase_r};

endmodule

>>> hw/rtl/sbce_jobq.sv
// Small job queue between the front end and the back end.
// Uses sbce_pkg for the job type.
`timescale 1ns / 1ps

module sbce_jobq #(
  parameter int Depth = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sbce_pkg::job_t wr_job,
  output logic           full,
  input  logic           pop,
  output sbce_pkg::job_t rd_job,
  output logic           empty
);
  import sbce_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == FullCnt);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/sbce_back.sv
// Back end: expands each job into result items, one per cycle while the output
// register read via the result queue ports is empty or popped. Uses sbce_pkg.
`timescale 1ns / 1ps

module sbce_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    job_empty,
  input  sbce_pkg::job_t          job,
  output logic                    job_pop,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [1:0]              out_kind,
  output logic [7:0]              out_byte_value,
  output logic [31:0]             out_address,
  output logic [31:0]             out_clear_length,
  output logic                    out_led_on,
  output logic                    out_last,
  output sbce_pkg::back_status_t  status
);
  import sbce_pkg::*;

  logic [2:0]  step_r, step_nxt;
  logic        valid_r, valid_nxt;
  logic [1:0]  kind_r;
  logic [7:0]  byte_r;
  logic [31:0] addr_r;
  logic [31:0] len_r;
  logic        led_r;
  logic        last_r;
  logic [1:0]  r_kind;
  logic [7:0]  r_byte;
  logic [31:0] r_addr;
  logic [31:0] r_len;
  logic        r_led;
  logic        r_last;
  logic        advance;

  function automatic logic [7:0] pick_byte(input logic [31:0] w, input logic [1:0] i);
    return w[{i, 3'b000} +: 8];
  endfunction

  assign advance = !job_empty && (!valid_r || out_pop);

  // Result for the current job at the current step.
  always_comb begin
    r_kind = KIND_TX;
    r_byte = 8'd0;
    r_addr = 32'd0;
    r_len  = 32'd0;
    r_led  = 1'b1;
    r_last = 1'b0;
    unique case (job.op)
      OP_REPLY: begin
        r_byte = job.byte_value;
        r_last = 1'b1;
      end
      OP_EXEC: begin
        r_led = 1'b0;
        if (step_r == 3'd0) begin
          r_byte = EXEC_ACK;
        end else begin
          r_kind = KIND_START;
          r_last = 1'b1;
        end
      end
      OP_WRITE: begin
        r_kind = KIND_WRITE;
        r_byte = job.byte_value;
        r_addr = job.address;
        r_last = 1'b1;
      end
      OP_WRITE_DONE: begin
        priority if (step_r == 3'd0) begin
          r_kind = KIND_WRITE;
          r_byte = job.byte_value;
          r_addr = job.address;
        end else if (step_r == 3'd1) begin
          r_byte = LOAD_ACK;
        end else begin
          r_byte = pick_byte(job.arg, 2'(step_r - 3'd2));
          r_last = (step_r == 3'd5);
        end
      end
      OP_LOAD_DONE: begin
        if (step_r == 3'd0) begin
          r_byte = LOAD_ACK;
        end else begin
          r_byte = pick_byte(job.arg, 2'(step_r - 3'd1));
          r_last = (step_r == 3'd4);
        end
      end
      OP_CLEAR: begin
        if (step_r == 3'd0) begin
          r_kind = KIND_CLEAR;
          r_addr = job.address;
          r_len  = job.arg;
        end else begin
          r_byte = CLEAR_ACK;
          r_last = 1'b1;
        end
      end
      default: begin
        r_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    job_pop   = 1'b0;
    if (advance) begin
      valid_nxt = 1'b1;
      if (r_last) begin
        job_pop  = 1'b1;
        step_nxt = 3'd0;
      end else begin
        step_nxt = step_r + 3'd1;
      end
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r <= r_kind;
      byte_r <= r_byte;
      addr_r <= r_addr;
      len_r  <= r_len;
      led_r  <= r_led;
      last_r <= r_last;
    end
  end

  assign out_empty        = !valid_r;
  assign out_kind         = kind_r;
  assign out_byte_value   = byte_r;
  assign out_address      = addr_r;
  assign out_clear_length = len_r;
  assign out_led_on       = led_r;
  assign out_last         = last_r;
  assign status           = '{busy: (step_r != 3'd0), step: step_r};

endmodule

>>> hw/rtl/serial_boot_command_engine.sv
// Serial boot command engine. Received UART bytes go in through a queue-style
// port (push/full) and every result of the boot protocol (transmit bytes,
// memory byte writes, a clear request, start program) comes out through a
// queue-style port (empty/pop), the oldest first, with last marking the final
// result of each byte. The front end takes one byte per cycle while its job
// queue (JobDepth entries) has room; header bytes make no job. The back end
// emits one result per cycle while its output is empty or popped. A byte has
// one result in most cases, two for Execute and Clear, five for a zero-length
// load and six for the final data byte of a load. After Execute every byte
// is still taken but ignored until reset.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps
`include "serial_boot_command_engine_assert.svh"

module serial_boot_command_engine #(
  parameter int JobDepth = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte_value,
  output logic [31:0] out_address,
  output logic [31:0] out_clear_length,
  output logic        out_led_on,
  output logic        out_last
);
  import sbce_pkg::*;

  job_t          fe_job;
  job_t          q_job;
  logic          fe_push;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  front_status_t fe_status;
  back_status_t  be_status;

  assign in_full = q_full;

  sbce_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .job_full   (q_full),
    .job_push   (fe_push),
    .job        (fe_job),
    .status     (fe_status)
  );

  sbce_jobq #(
    .Depth (JobDepth)
  ) u_jobq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (fe_push),
    .wr_job (fe_job),
    .full   (q_full),
    .pop    (q_pop),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  sbce_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_empty        (q_empty),
    .job              (q_job),
    .job_pop          (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_kind         (out_kind),
    .out_byte_value   (out_byte_value),
    .out_address      (out_address),
    .out_clear_length (out_clear_length),
    .out_led_on       (out_led_on),
    .out_last         (out_last),
    .status           (be_status)
  );

  // Once halted, the front end must produce no further work and stay halted.
  `SBCE_ASSERT_NOW(a_halt_no_job, clk, rst_n, fe_status.halted, !fe_push, "job after halt")
  `SBCE_ASSERT_NEXT(a_halt_sticky, clk, rst_n, fe_status.halted, fe_status.halted, "halt lost")
  // A start-program result is the final one of its byte and has the LED off.
  `SBCE_ASSERT_NOW(a_start_form, clk, rst_n, !out_empty && out_kind == KIND_START,
                   out_last && !out_led_on, "malformed start result")
  // The back end only releases a job that is present, and only at its last step.
  `SBCE_ASSERT_NOW(a_pop_valid, clk, rst_n, q_pop, !q_empty, "job popped from empty queue")
  `SBCE_ASSERT_NEXT(a_pop_resets_step, clk, rst_n, q_pop, !be_status.busy,
                    "sequencer not back at first step after a job")

endmodule
